// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the decoder core (pbrd_core).
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// ----- hw/rtl/pbrd_pkg.sv -----
package pbrd_pkg;

    // Decoder phase within a compressed row
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    // Header byte that does nothing
    localparam logic [7:0] HDR_NOP = 8'h80;

    // Largest run a single header can describe
    localparam logic [7:0] RUN_MAX = 8'd128;

    // Configuration register indexes
    localparam logic CFG_ROW_WIDTH  = 1'b0;
    localparam logic CFG_COMPRESSED = 1'b1;

    // One compressed input byte with its markers
    typedef struct packed {
        logic [7:0] code_byte;
        logic       row_last;
        logic       image_last;
    } item_t;

    // One run descriptor
    typedef struct packed {
        logic [7:0] run_value;
        logic [7:0] run_count;
        logic       row_done;
        logic       image_done;
    } run_t;

endpackage

// ----- hw/rtl/pbrd_in_reg.sv -----
module pbrd_in_reg
    import pbrd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_pop,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // Take a new request when empty or when the held one leaves this cycle
    assign in_ready   = !valid_reg || item_pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- hw/rtl/pbrd_core.sv -----
`include "assert_macros.svh"

module pbrd_core
    import pbrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] cfg_row_width,
    input  logic        cfg_compressed,
    input  logic        item_valid,
    input  item_t       item,
    input  logic        res_ready,
    output logic        item_pop,
    output logic        res_emit,
    output run_t        res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  lit_left_reg, lit_left_next;
    logic [7:0]  rep_len_reg, rep_len_next;
    logic [15:0] row_pos_reg, row_pos_next;

    logic [7:0]  want;
    logic [7:0]  cnt;
    logic        rdone;
    logic [15:0] room;
    logic [15:0] pos_base;
    logic [15:0] pos_inc;
    logic [15:0] pos_sum;

    // Advance one item whenever the result register can take it
    assign item_pop = item_valid && res_ready;
    assign res_emit = cnt != 8'd0;

    assign res.run_value  = item.code_byte;
    assign res.run_count  = cnt;
    assign res.row_done   = rdone;
    assign res.image_done = item.image_last;

    // Decode one byte against the current state
    always_comb begin
        phase_next    = phase_reg;
        lit_left_next = lit_left_reg;
        rep_len_next  = rep_len_reg;
        row_pos_next  = row_pos_reg;
        want          = 8'd0;
        cnt           = 8'd0;
        rdone         = 1'b0;
        room          = cfg_row_width - row_pos_reg;
        pos_base      = (row_pos_reg >= cfg_row_width) ? 16'd0 : row_pos_reg;
        pos_inc       = pos_base + 16'd1;
        pos_sum       = row_pos_reg;

        if (!cfg_compressed) begin
            // Raw bytes: one per run, wrap at the row width
            if (cfg_row_width != 16'd0) begin
                cnt = 8'd1;
                if (pos_inc == cfg_row_width) begin
                    rdone        = 1'b1;
                    row_pos_next = 16'd0;
                end else begin
                    row_pos_next = pos_inc;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (item.code_byte < HDR_NOP) begin
                        lit_left_next = item.code_byte + 8'd1;
                        phase_next    = PH_LITERAL;
                    end else if (item.code_byte > HDR_NOP) begin
                        // 257 - n, kept in eight bits
                        rep_len_next = ~item.code_byte + 8'd2;
                        phase_next   = PH_REPEAT;
                    end
                end
                PH_LITERAL: begin
                    want          = 8'd1;
                    lit_left_next = lit_left_reg - 8'd1;
                    if (lit_left_next == 8'd0) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_REPEAT: begin
                    want       = rep_len_reg;
                    phase_next = PH_HEADER;
                end
                PH_SKIP: begin
                    want = 8'd0;
                end
            endcase

            // Clip the run to the room left in the row
            if (want != 8'd0 && row_pos_reg < cfg_row_width) begin
                cnt          = ({8'd0, want} < room) ? want : room[7:0];
                pos_sum      = row_pos_reg + {8'd0, cnt};
                row_pos_next = pos_sum;
                if (pos_sum == cfg_row_width) begin
                    rdone         = 1'b1;
                    phase_next    = PH_SKIP;
                    lit_left_next = 8'd0;
                end
            end

            // Row end marker drops whatever is left of the row
            if (item.row_last) begin
                phase_next    = PH_HEADER;
                lit_left_next = 8'd0;
                rep_len_next  = 8'd0;
                row_pos_next  = 16'd0;
            end
        end

        // Image end marker restarts everything
        if (item.image_last) begin
            phase_next    = PH_HEADER;
            lit_left_next = 8'd0;
            rep_len_next  = 8'd0;
            row_pos_next  = 16'd0;
        end
    end

    // Update decoder state per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            lit_left_reg <= 8'd0;
            rep_len_reg  <= 8'd0;
            row_pos_reg  <= 16'd0;
        end else if (item_pop) begin
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            rep_len_reg  <= rep_len_next;
            row_pos_reg  <= row_pos_next;
        end
    end

    `ASSERT_NEVER(a_literal_count, aclk, aresetn, phase_reg == PH_LITERAL && lit_left_reg == 8'd0, "literal phase with nothing left")
    `ASSERT_NEVER(a_repeat_len, aclk, aresetn, phase_reg == PH_REPEAT && (rep_len_reg < 8'd2 || rep_len_reg > RUN_MAX), "repeat length out of range")
    `ASSERT_NEVER(a_count_range, aclk, aresetn, item_valid && cnt > RUN_MAX, "run count above limit")
    `ASSERT_PROP(a_full_row_skips, aclk, aresetn, item_pop && cfg_compressed && rdone && !item.row_last && !item.image_last |=> phase_reg == PH_SKIP, "full row did not enter skip")

endmodule

// ----- hw/rtl/pbrd_out_reg.sv -----
module pbrd_out_reg
    import pbrd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  logic load_emit,
    input  run_t load_run,
    output logic load_ready,
    output logic out_valid,
    input  logic out_ready,
    output run_t out_run
);

    logic valid_reg;
    run_t run_reg;

    // Free when empty or when the held result is taken this cycle
    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_run    = run_reg;

    // Hold valid flag; bytes without a run leave it empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load && load_emit;
        end
    end

    // Capture the run descriptor
    always_ff @(posedge aclk) begin
        if (load_ready && load && load_emit) begin
            run_reg <= load_run;
        end
    end

endmodule

// ----- hw/rtl/packbits_row_decoder.sv -----
// PackBits row decoder: takes one compressed byte per request on the s_ side
// and returns one run descriptor (byte value, repeat count 1..128) on the m_
// side for each byte that places data in the row; headers, no-op bytes and
// bytes past a full row give no result. Throughput is one byte per clock
// while m_tready stays high. The input register and the result register
// sit around the single decode stage. The row position, phase and run
// counters update once per accepted byte. Write row_width and compressed
// only while no byte is in flight.
module packbits_row_decoder
    import pbrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tlast,   // row_last
    input  logic        s_tuser,   // [0] image_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] run_value, [15:8] run_count
    output logic        m_tlast,   // row_done
    output logic        m_tuser    // [0] image_done
);

    logic [15:0] row_width_reg;
    logic        compressed_reg;

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  item_pop;
    logic  res_ready;
    logic  res_emit;
    run_t  res;
    run_t  out_run;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg  <= 16'd1;
            compressed_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW_WIDTH:  row_width_reg  <= cfg_wdata;
                CFG_COMPRESSED: compressed_reg <= cfg_wdata[0];
            endcase
        end
    end

    assign in_item.code_byte  = s_tdata;
    assign in_item.row_last   = s_tlast;
    assign in_item.image_last = s_tuser;

    pbrd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    pbrd_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_row_width  (row_width_reg),
        .cfg_compressed (compressed_reg),
        .item_valid     (item_valid),
        .item           (item),
        .res_ready      (res_ready),
        .item_pop       (item_pop),
        .res_emit       (res_emit),
        .res            (res)
    );

    pbrd_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (item_pop),
        .load_emit  (res_emit),
        .load_run   (res),
        .load_ready (res_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_run    (out_run)
    );

    assign m_tdata = {out_run.run_count, out_run.run_value};
    assign m_tlast = out_run.row_done;
    assign m_tuser = out_run.image_done;

endmodule

// ----- test/packbits_row_decoder_test.sv -----
`timescale 1ns / 1ps

module packbits_row_decoder_test;
    import pbrd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES = 300;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] code_byte
    logic        s_tlast;   // row_last
    logic        s_tuser;   // [0] image_last
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] run_value, [15:8] run_count
    logic        m_tlast;   // row_done
    logic        m_tuser;   // [0] image_done

    packbits_row_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Decoder state as the testbench sees it
    logic [15:0] width_q;
    bit          comp_q;
    phase_t      ph_q;
    logic [7:0]  lit_left_q;
    logic [7:0]  rep_len_q;
    logic [15:0] row_pos_q;

    run_t        runs_due[$];
    int unsigned bytes_sent;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          calm;
    int unsigned hold_asked;

    function automatic void clear_decoder();
        ph_q = PH_HEADER;
        lit_left_q = '0;
        rep_len_q = '0;
        row_pos_q = '0;
    endfunction

    // Advance the decoder by one byte; return 1 when it places a run in the row
    function automatic bit decode_byte(input logic [7:0] code, input bit rlast,
                                       input bit ilast, output run_t run);
        int unsigned want;
        int unsigned cnt;
        int unsigned room;
        bit          rdone;
        want = 0;
        cnt = 0;
        rdone = 1'b0;
        if (!comp_q) begin
            // Raw bytes: count through the row and wrap
            if (width_q != 0) begin
                if (row_pos_q >= width_q)
                    row_pos_q = '0;
                row_pos_q++;
                cnt = 1;
                if (row_pos_q == width_q) begin
                    rdone = 1'b1;
                    row_pos_q = '0;
                end
            end
        end else begin
            case (ph_q)
                PH_HEADER: begin
                    if (code < HDR_NOP) begin
                        lit_left_q = code + 8'd1;
                        ph_q = PH_LITERAL;
                    end else if (code > HDR_NOP) begin
                        rep_len_q = 8'(9'd257 - code);
                        ph_q = PH_REPEAT;
                    end
                end
                PH_LITERAL: begin
                    want = 1;
                    lit_left_q--;
                    if (lit_left_q == 0)
                        ph_q = PH_HEADER;
                end
                PH_REPEAT: begin
                    want = rep_len_q;
                    ph_q = PH_HEADER;
                end
                default: ;
            endcase
            // Clip the run to the room left in the row
            if (want != 0 && row_pos_q < width_q) begin
                room = width_q - row_pos_q;
                cnt = (want < room) ? want : room;
                row_pos_q += 16'(cnt);
                if (row_pos_q == width_q) begin
                    rdone = 1'b1;
                    ph_q = PH_SKIP;
                    lit_left_q = '0;
                end
            end
            if (rlast)
                clear_decoder();
        end
        run.run_value = code;
        run.run_count = cnt[7:0];
        run.row_done = rdone;
        run.image_done = ilast;
        if (ilast)
            clear_decoder();
        return cnt != 0;
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d runs outstanding", $time, runs_due.size());
                $display("packbits_row_decoder_test: FAIL");
                $finish;
            end
        end
    end

    // Result side: drive m_tready and check every accepted run
    initial begin
        run_t        got;
        run_t        want;
        int unsigned hold_taken;
        int unsigned hold_left;
        hold_taken = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.run_value = m_tdata[7:0];
                got.run_count = m_tdata[15:8];
                got.row_done = m_tlast;
                got.image_done = m_tuser;
                if (runs_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected run: expected none, got %h/%0d/%b/%b",
                             $time, got.run_value, got.run_count, got.row_done,
                             got.image_done);
                end else begin
                    want = runs_due.pop_front();
                    if (got.run_value !== want.run_value || got.run_count !== want.run_count ||
                        got.row_done !== want.row_done || got.image_done !== want.image_done) begin
                        mismatches++;
                        $display("%0t: run mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                                 $time, want.run_value, want.run_count, want.row_done,
                                 want.image_done, got.run_value, got.run_count,
                                 got.row_done, got.image_done);
                    end
                end
            end
            // Start a long hold-off when asked, else stall at random
            if (hold_asked != hold_taken) begin
                hold_taken = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 29);
            end
        end
    end

    // Offer one byte, hold it until accepted, then record the run it causes
    task automatic send_byte(input logic [7:0] code, input bit rlast, input bit ilast);
        run_t run;
        // Idle at random first, unless calm is set
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        s_tlast <= rlast;
        s_tuser <= ilast;
        do @(posedge aclk); while (!s_tready);
        if (decode_byte(code, rlast, ilast, run))
            runs_due.push_back(run);
        bytes_sent++;
    endtask

    // Drop the request, wait for every run, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [15:0] width, input bit comp);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROW_WIDTH;
        cfg_wdata <= width;
        @(posedge aclk);
        width_q = width;
        cfg_index <= CFG_COMPRESSED;
        cfg_wdata <= {15'd0, comp};
        @(posedge aclk);
        comp_q = comp;
        cfg_wr_en <= 1'b0;
    endtask

    // Random bytes with random markers
    task automatic send_loose_bytes(input int unsigned count);
        repeat (count)
            send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(15) == 0);
    endtask

    // Build one PackBits row aimed at the width, sometimes over or short, sometimes broken
    task automatic send_packbits_row(input int unsigned width);
        logic [7:0]  row_q[$];
        int unsigned target;
        int unsigned made;
        int unsigned cap;
        int unsigned len;
        int unsigned k;
        bit          ilast;
        target = (width == 0) ? $urandom_range(1, 20) : ((width > 160) ? 160 : width);
        if ($urandom_range(3) == 0)
            target += $urandom_range(1, 20);
        else if ($urandom_range(5) == 0)
            target = $urandom_range(1, target);
        made = 0;
        while (made < target) begin
            cap = target - made;
            if (cap > 128)
                cap = 128;
            k = $urandom_range(9);
            if (k == 0) begin
                row_q.push_back(HDR_NOP);
            end else if (k < 5) begin
                len = ($urandom_range(4) == 0) ? $urandom_range(1, 128) : $urandom_range(1, cap);
                row_q.push_back(8'(len - 1));
                repeat (len) row_q.push_back(8'($urandom));
                made += len;
            end else begin
                len = ($urandom_range(4) == 0 || cap < 2) ? $urandom_range(2, 128)
                                                          : $urandom_range(2, cap);
                row_q.push_back(8'(257 - len));
                row_q.push_back(8'($urandom));
                made += len;
            end
        end
        // Cut the row short or slip in a stray byte now and then
        if ($urandom_range(9) == 0 && row_q.size() > 1)
            repeat ($urandom_range(1, row_q.size() - 1)) void'(row_q.pop_back());
        if ($urandom_range(9) == 0)
            row_q.insert($urandom_range(row_q.size()), 8'($urandom));
        ilast = ($urandom_range(7) == 0);
        foreach (row_q[i])
            send_byte(row_q[i], i == row_q.size() - 1, ilast && (i == row_q.size() - 1));
    endtask

    task automatic test_directed();
        // Literal, no-op, repeat, overlong repeat, bytes after a full row
        program_regs(16'd8, 1'b1);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(HDR_NOP, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        // Row end in the middle of a literal, then image end on a clipped run
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h83, 1'b0, 1'b0);
        send_byte(8'h77, 1'b0, 1'b1);
        // Zero width: nothing fits, image end without a run
        program_regs(16'd0, 1'b1);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h11, 1'b0, 1'b1);
        // Widest row
        program_regs(16'hFFFF, 1'b1);
        send_byte(8'h81, 1'b0, 1'b0);
        send_byte(8'hEE, 1'b1, 1'b0);
        // Width lowered below the row position, compressed
        program_regs(16'd100, 1'b1);
        send_byte(8'hF0, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        program_regs(16'd10, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h56, 1'b1, 1'b0);
        // Raw mode, then width lowered mid-row
        program_regs(16'd5, 1'b0);
        repeat (3) send_byte(8'($urandom), 1'b0, 1'b0);
        program_regs(16'd2, 1'b0);
        send_byte(8'h99, 1'b1, 1'b0);
        send_byte(8'h42, 1'b0, 1'b1);
    endtask

    task automatic test_random_rows();
        int unsigned pick;
        int unsigned width;
        bit          comp;
        while (bytes_sent < RANDOM_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 30)
                width = $urandom_range(1, 8);
            else if (pick < 75)
                width = $urandom_range(9, 64);
            else if (pick < 88)
                width = $urandom_range(65, 400);
            else if (pick < 94)
                width = 0;
            else
                width = 65535;
            comp = ($urandom_range(99) < 85);
            program_regs(width[15:0], comp);
            repeat ($urandom_range(2, 6)) begin
                // Stop adding groups once the byte budget is spent
                if (bytes_sent < RANDOM_BYTES) begin
                    if (!comp)
                        send_loose_bytes($urandom_range(5, 30));
                    else if ($urandom_range(9) == 0)
                        send_loose_bytes($urandom_range(1, 8));
                    else
                        send_packbits_row(width);
                end
            end
        end
    endtask

    // Hold the result side off while bytes keep coming, so the block stalls its input
    task automatic test_backpressure();
        program_regs(16'd5, 1'b0);
        calm = 1'b1;
        hold_asked++;
        send_loose_bytes(40);
        calm = 1'b0;
        // Pause the sender until every run is out
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        program_regs(16'd200, 1'b1);
        hold_asked++;
        repeat (3) send_packbits_row(200);
    endtask

    // A long stretch with no idling on either side
    task automatic test_calm_stretch();
        int unsigned stop_at;
        program_regs(16'd48, 1'b1);
        calm = 1'b1;
        stop_at = bytes_sent + 120;
        while (bytes_sent < stop_at)
            send_packbits_row(48);
        calm = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_ROW_WIDTH;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        s_tuser <= 1'b0;
        calm = 1'b0;
        hold_asked = 0;
        bytes_sent = 0;
        mismatches = 0;
        width_q = 16'd1;
        comp_q = 1'b1;
        clear_decoder();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_rows();
        test_backpressure();
        test_calm_stretch();

        settle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("packbits_row_decoder_test: PASS");
        else
            $display("packbits_row_decoder_test: FAIL");
        $finish;
    end

endmodule
